[rtl/core/kabf_pkg.sv]
// ----------------------------------------------------------------------------
// kabf_pkg: shared types and helpers of the angle and bias Kalman filter
// Beat formats, command and register codes, sequencer states and the
// saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int unsigned FracBitsDefault = 24;
  localparam int unsigned CfgWidth        = 25;
  localparam int unsigned CfgIdxWidth     = 2;

  localparam logic [CfgWidth-1:0] QAngleReset = 25'd16777;
  localparam logic [CfgWidth-1:0] QBiasReset  = 25'd33554;
  localparam logic [CfgWidth-1:0] RMeasReset  = 25'd335544;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_MEAS  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_UPDATE    = 2'd0,
    CMD_RESTART   = 2'd1,
    CMD_SET_ANGLE = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic [24:0]        time_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] unbiased_rate;
    logic               numeric_flag;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_MA, S_ANG, S_MDB, S_T, S_MT, S_P00, S_P11, S_S, S_CHK,
    S_DIV0, S_K0, S_DIV1, S_K1, S_MY0, S_UA, S_UB, S_C0, S_C1, S_C2, S_C3,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  localparam logic signed [65:0] SatMax = 66'sd2147483647;
  localparam logic signed [65:0] SatMin = -66'sd2147483648;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (v < SatMin) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/core/kabf_stream_if.sv]
// ----------------------------------------------------------------------------
// kabf_stream_if: valid/ready stream channel
// Carries one payload beat per handshake; source drives, sink takes.
// ----------------------------------------------------------------------------
interface kabf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/kalman_angle_bias_filter.sv]
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state Kalman filter for angle and gyro bias
// Channel  Dir  Beat
// in_if    in   command, measured_angle, measured_rate, time_step
// out_if   out  angle_estimate, unbiased_rate, numeric_flag
// cfg_*    in   noise register writes, index and 25-bit data
// An update beat forms both gains in a radix-2 divider, one bit a cycle;
// in_if is ready only while idle, so no beat is taken during an update.
// One shared 32x32 multiplier serves all products, one per cycle.
// Restart, set-angle and unused commands skip the update and go straight to S_DONE.
// Reset clears the state and loads the default noise registers.
// A new beat is taken while a finished result waits on the output register.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter #(
  parameter int unsigned FRAC_BITS = kabf_pkg::FracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kabf_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [kabf_pkg::CfgWidth-1:0]       cfg_wdata_i,
  kabf_stream_if.sink                         in_if,
  kabf_stream_if.source                       out_if
);
  import kabf_pkg::*;

  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [CntW-1:0] CntStart = CntW'(NumW);

  state_e state_q, state_d;

  logic [CfgWidth-1:0] qa_q, qa_d, qb_q, qb_d, rm_q, rm_d;
  logic signed [31:0] meas_q, meas_d, mrate_q, mrate_d;
  logic [24:0] dt_q, dt_d;
  logic signed [31:0] angle_q, angle_d, bias_q, bias_d, last_rate_q, last_rate_d;
  logic signed [31:0] aa_q, aa_d, ab_q, ab_d, ba_q, ba_d, bb_q, bb_d;
  logic signed [31:0] rate_q, rate_d, ang_q, ang_d, mdb_q, mdb_d, t_q, t_d;
  logic signed [31:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  logic signed [31:0] s_q, s_d, k0_q, k0_d, k1_q, k1_d, y_q, y_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] mul_a, mul_b;
  logic [31:0] rem_q, rem_d, den_q, den_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d, flag_q, flag_d;
  logic out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  logic in_fire, out_load;
  logic signed [64:0] prod_rnd, prod_shr;
  sat_t mr, dres, sa, sb, sc;
  logic [32:0] rem_sh;
  logic [NumW-1:0] dnum;

  function automatic logic signed [65:0] sx(input logic signed [31:0] v);
    return 66'(v);
  endfunction

  function automatic logic signed [65:0] ux(input logic [CfgWidth-1:0] v);
    return $signed({{(66 - CfgWidth){1'b0}}, v});
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign in_fire    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_if.ready);
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  assign prod_rnd = {prod_q[63], prod_q} + (65'sd1 <<< (FRAC_BITS - 1));
  assign prod_shr = prod_rnd >>> FRAC_BITS;
  assign mr       = sat32(66'(prod_shr));
  assign dres     = sat32(neg_q ? -$signed({{(66 - NumW){1'b0}}, quo_q})
                                :  $signed({{(66 - NumW){1'b0}}, quo_q}));
  assign rem_sh   = {rem_q, quo_q[NumW-1]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_if.payload.command == CMD_UPDATE) ? S_RATE : S_DONE;
        end
      end
      S_RATE: state_d = S_MA;
      S_MA:   state_d = S_ANG;
      S_ANG:  state_d = S_MDB;
      S_MDB:  state_d = S_T;
      S_T:    state_d = S_MT;
      S_MT:   state_d = S_P00;
      S_P00:  state_d = S_P11;
      S_P11:  state_d = S_S;
      S_S:    state_d = S_CHK;
      S_CHK:  state_d = (s_q == 32'sd0) ? S_DONE : S_DIV0;
      S_DIV0: state_d = (cnt_q == '0) ? S_K0 : S_DIV0;
      S_K0:   state_d = S_DIV1;
      S_DIV1: state_d = (cnt_q == '0) ? S_K1 : S_DIV1;
      S_K1:   state_d = S_MY0;
      S_MY0:  state_d = S_UA;
      S_UA:   state_d = S_UB;
      S_UB:   state_d = S_C0;
      S_C0:   state_d = S_C1;
      S_C1:   state_d = S_C2;
      S_C2:   state_d = S_C3;
      S_C3:   state_d = S_DONE;
      S_DONE: state_d = out_load ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    qa_d = qa_q; qb_d = qb_q; rm_d = rm_q;
    meas_d = meas_q; mrate_d = mrate_q; dt_d = dt_q;
    angle_d = angle_q; bias_d = bias_q; last_rate_d = last_rate_q;
    aa_d = aa_q; ab_d = ab_q; ba_d = ba_q; bb_d = bb_q;
    rate_d = rate_q; ang_d = ang_q; mdb_d = mdb_q; t_d = t_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    s_d = s_q; k0_d = k0_q; k1_d = k1_q; y_d = y_q;
    rem_d = rem_q; den_d = den_q; quo_d = quo_q; cnt_d = cnt_q; neg_d = neg_q;
    flag_d = flag_q;
    mul_a = 32'sd0; mul_b = 32'sd0;
    out_valid_d = out_valid_q; out_d = out_q;
    sa = '0; sb = '0; sc = '0;
    dnum = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_Q_ANGLE: qa_d = cfg_wdata_i;
        REG_Q_BIAS:  qb_d = cfg_wdata_i;
        REG_R_MEAS:  rm_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          meas_d  = in_if.payload.measured_angle;
          mrate_d = in_if.payload.measured_rate;
          dt_d    = in_if.payload.time_step;
          flag_d  = 1'b0;
          case (in_if.payload.command)
            CMD_RESTART: begin
              angle_d = in_if.payload.measured_angle;
              bias_d = '0; aa_d = '0; ab_d = '0; ba_d = '0; bb_d = '0;
            end
            CMD_SET_ANGLE: angle_d = in_if.payload.measured_angle;
            default: ;
          endcase
        end
      end
      S_RATE: begin
        sa = sat32(sx(mrate_q) - sx(bias_q));
        rate_d = sa.val; flag_d = flag_q | sa.ovf;
      end
      S_MA: begin
        mul_a = $signed({7'b0, dt_q}); mul_b = rate_q;
      end
      S_ANG: begin
        sa = sat32(sx(angle_q) + sx(mr.val));
        ang_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = $signed({7'b0, dt_q}); mul_b = bb_q;
      end
      S_MDB: begin
        mdb_d = mr.val; flag_d = flag_q | mr.ovf;
      end
      S_T: begin
        sa = sat32(sx(mdb_q) - sx(ab_q) - sx(ba_q) + ux(qa_q));
        sb = sat32(sx(ab_q) - sx(mdb_q));
        sc = sat32(sx(ba_q) - sx(mdb_q));
        t_d = sa.val; p01_d = sb.val; p10_d = sc.val;
        flag_d = flag_q | sa.ovf | sb.ovf | sc.ovf;
      end
      S_MT: begin
        mul_a = $signed({7'b0, dt_q}); mul_b = t_q;
      end
      S_P00: begin
        sa = sat32(sx(aa_q) + sx(mr.val));
        p00_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = $signed({7'b0, qb_q}); mul_b = $signed({7'b0, dt_q});
      end
      S_P11: begin
        sa = sat32(sx(bb_q) + sx(mr.val));
        p11_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
      end
      S_S: begin
        sa = sat32(sx(p00_q) + ux(rm_q));
        s_d = sa.val; flag_d = flag_q | sa.ovf;
      end
      S_CHK: begin
        if (s_q == 32'sd0) begin
          flag_d = 1'b1;
        end else begin
          dnum = {mag(p00_q), {FRAC_BITS{1'b0}}};
          rem_d = '0; quo_d = dnum; cnt_d = CntStart;
          den_d = mag(s_q); neg_d = p00_q[31] ^ s_q[31];
        end
      end
      S_DIV0, S_DIV1: begin
        if (cnt_q != '0) begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_d = 32'(rem_sh - {1'b0, den_q});
            quo_d = {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[31:0];
            quo_d = {quo_q[NumW-2:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_K0: begin
        k0_d = dres.val; flag_d = flag_q | dres.ovf;
        dnum = {mag(p10_q), {FRAC_BITS{1'b0}}};
        rem_d = '0; quo_d = dnum; cnt_d = CntStart;
        neg_d = p10_q[31] ^ s_q[31];
      end
      S_K1: begin
        k1_d = dres.val;
        sa = sat32(sx(meas_q) - sx(ang_q));
        y_d = sa.val; flag_d = flag_q | dres.ovf | sa.ovf;
      end
      S_MY0: begin
        mul_a = k0_q; mul_b = y_q;
      end
      S_UA: begin
        sa = sat32(sx(ang_q) + sx(mr.val));
        angle_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = k1_q; mul_b = y_q;
      end
      S_UB: begin
        sa = sat32(sx(bias_q) + sx(mr.val));
        bias_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = k0_q; mul_b = p00_q;
      end
      S_C0: begin
        sa = sat32(sx(p00_q) - sx(mr.val));
        aa_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = k0_q; mul_b = p01_q;
      end
      S_C1: begin
        sa = sat32(sx(p01_q) - sx(mr.val));
        ab_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = k1_q; mul_b = p00_q;
      end
      S_C2: begin
        sa = sat32(sx(p10_q) - sx(mr.val));
        ba_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        mul_a = k1_q; mul_b = p01_q;
      end
      S_C3: begin
        sa = sat32(sx(p11_q) - sx(mr.val));
        bb_d = sa.val; flag_d = flag_q | mr.ovf | sa.ovf;
        last_rate_d = rate_q;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d.angle_estimate = angle_q;
          out_d.unbiased_rate  = last_rate_q;
          out_d.numeric_flag   = flag_q;
        end
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      qa_q <= QAngleReset; qb_q <= QBiasReset; rm_q <= RMeasReset;
      angle_q <= '0; bias_q <= '0; last_rate_q <= '0;
      aa_q <= '0; ab_q <= '0; ba_q <= '0; bb_q <= '0;
      cnt_q <= '0; flag_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      qa_q <= qa_d; qb_q <= qb_d; rm_q <= rm_d;
      angle_q <= angle_d; bias_q <= bias_d; last_rate_q <= last_rate_d;
      aa_q <= aa_d; ab_q <= ab_d; ba_q <= ba_d; bb_q <= bb_d;
      cnt_q <= cnt_d; flag_q <= flag_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q <= meas_d; mrate_q <= mrate_d; dt_q <= dt_d;
    rate_q <= rate_d; ang_q <= ang_d; mdb_q <= mdb_d; t_q <= t_d;
    p00_q <= p00_d; p01_q <= p01_d; p10_q <= p10_d; p11_q <= p11_d;
    s_q <= s_d; k0_q <= k0_d; k1_q <= k1_d; y_q <= y_d;
    prod_q <= prod_d;
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; neg_q <= neg_d;
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("Sequencer stayed idle after taking a beat.");
  a_zero_divisor_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && s_q == 32'sd0) |=> (flag_q && state_q == S_DONE))
    else $error("Zero innovation variance did not raise the flag.");
  a_div_count_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K0 || state_q == S_K1) |-> cnt_q == '0)
    else $error("Gain taken before the division finished.");
`endif

endmodule
